FILE: rtl/lpht_pkg.sv
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int KEY_W          = 31;
    localparam int HANDLE_W       = 32;
    localparam int TABLE_SIZE_W   = 7;
    localparam int SLOT_INDEX_W   = 6;
    localparam int ENTRY_W        = 1 + KEY_W + HANDLE_W;

    localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RST = 7'd64;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } command_t;

endpackage

FILE: rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// command   in         start high, busy low    command, key, record_handle
// result    out        done strobe, one cycle  status, found_handle, slot_index
// config    in         cfg_we                  cfg_wdata (table size)
//
// an item is accepted, then the bit-serial remainder unit reduces the key to the
// home slot, one read is issued, and then the slot memory is probed one slot per
// cycle (from 1 probe up to the table size)
// after reset a clearing pass writes every slot empty, with busy high
// results cannot be stalled; done is high for exactly one cycle per item

module linear_probe_hash_table #(
    parameter int CAPACITY = lpht_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lpht_pkg::TABLE_SIZE_W-1:0]    cfg_wdata,
    input  logic                                 start,
    output logic                                 busy,
    input  lpht_pkg::command_t                   command,
    input  logic [lpht_pkg::KEY_W-1:0]           key,
    input  logic [lpht_pkg::HANDLE_W-1:0]        record_handle,
    output logic                                 done,
    output lpht_pkg::status_t                    status,
    output logic [lpht_pkg::HANDLE_W-1:0]        found_handle,
    output logic [lpht_pkg::SLOT_INDEX_W-1:0]    slot_index
);

    import lpht_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int SZW   = AW + 1;
    localparam int DCW   = $clog2(KEY_W);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_ISSUE,
        S_PROBE
    } state_t;

    state_t                  state_reg, state_next;
    logic [TABLE_SIZE_W-1:0] table_size_reg, table_size_next;
    command_t                cmd_reg, cmd_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [KEY_W-1:0]        key_sh_reg, key_sh_next;
    logic [HANDLE_W-1:0]     handle_reg, handle_next;
    logic [SZW-1:0]          size_reg, size_next;
    logic [SZW-1:0]          rem_reg, rem_next;
    logic [DCW-1:0]          div_cnt_reg, div_cnt_next;
    logic [AW-1:0]           slot_reg, slot_next;
    logic [SZW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic                    done_reg, done_next;
    status_t                 status_reg, status_next;
    logic [HANDLE_W-1:0]     found_handle_reg, found_handle_next;
    logic [SLOT_INDEX_W-1:0] slot_index_reg, slot_index_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;

    logic [SZW-1:0]          size_eff;
    logic [SZW:0]            rem_shift;
    logic [SZW:0]            rem_sub;
    logic [SZW-1:0]          rem_new;
    logic [SZW-1:0]          slot_plus;
    logic [AW-1:0]           slot_inc;
    logic                    rd_valid;
    logic [KEY_W-1:0]        rd_key;
    logic [HANDLE_W-1:0]     rd_handle;
    logic                    last_probe;

    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_valid  = ram_rdata[ENTRY_W-1];
    assign rd_key    = ram_rdata[HANDLE_W +: KEY_W];
    assign rd_handle = ram_rdata[HANDLE_W-1:0];

    always_comb
    begin
        if (table_size_reg == '0)
        begin
            size_eff = SZW'(1);
        end
        else if (32'(table_size_reg) > CAPACITY)
        begin
            size_eff = SZW'(CAPACITY);
        end
        else
        begin
            size_eff = SZW'(table_size_reg);
        end
    end

    // one remainder bit per cycle, rem stays below size
    assign rem_shift = {rem_reg, key_sh_reg[KEY_W-1]};
    assign rem_sub   = rem_shift - {1'b0, size_reg};
    assign rem_new   = (rem_shift >= {1'b0, size_reg}) ? rem_sub[SZW-1:0] : rem_shift[SZW-1:0];

    assign slot_plus  = {1'b0, slot_reg} + SZW'(1);
    assign slot_inc   = (slot_plus == size_reg) ? '0 : slot_plus[AW-1:0];
    assign last_probe = (cnt_reg == size_reg - SZW'(1));

    always_comb
    begin
        state_next        = state_reg;
        table_size_next   = table_size_reg;
        cmd_next          = cmd_reg;
        key_next          = key_reg;
        key_sh_next       = key_sh_reg;
        handle_next       = handle_reg;
        size_next         = size_reg;
        rem_next          = rem_reg;
        div_cnt_next      = div_cnt_reg;
        slot_next         = slot_reg;
        cnt_next          = cnt_reg;
        clr_next          = clr_reg;
        done_next         = 1'b0;
        status_next       = status_reg;
        found_handle_next = found_handle_reg;
        slot_index_next   = slot_index_reg;
        ram_we            = 1'b0;
        ram_waddr         = slot_reg;
        ram_wdata         = {1'b1, key_reg, handle_reg};
        ram_raddr         = slot_reg;

        if (cfg_we)
        begin
            table_size_next = cfg_wdata;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == AW'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next     = command;
                    key_next     = key;
                    key_sh_next  = key;
                    handle_next  = record_handle;
                    size_next    = size_eff;
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next     = rem_new;
                key_sh_next  = {key_sh_reg[KEY_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + DCW'(1);
                if (div_cnt_reg == DCW'(KEY_W - 1))
                begin
                    slot_next  = AW'(rem_new);
                    cnt_next   = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                ram_raddr  = slot_reg;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                ram_raddr = slot_inc;
                slot_next = slot_inc;
                cnt_next  = cnt_reg + SZW'(1);
                if (cmd_reg == CMD_INSERT)
                begin
                    if (!rd_valid)
                    begin
                        ram_we            = 1'b1;
                        ram_waddr         = slot_reg;
                        done_next         = 1'b1;
                        status_next       = ST_INSERTED;
                        found_handle_next = '0;
                        slot_index_next   = SLOT_INDEX_W'(slot_reg);
                        state_next        = S_IDLE;
                    end
                    else if (last_probe)
                    begin
                        done_next         = 1'b1;
                        status_next       = ST_FULL;
                        found_handle_next = '0;
                        slot_index_next   = '0;
                        state_next        = S_IDLE;
                    end
                end
                else
                begin
                    if (rd_valid && rd_key == key_reg)
                    begin
                        done_next         = 1'b1;
                        status_next       = ST_FOUND;
                        found_handle_next = rd_handle;
                        slot_index_next   = SLOT_INDEX_W'(slot_reg);
                        state_next        = S_IDLE;
                    end
                    else if (!rd_valid || last_probe)
                    begin
                        done_next         = 1'b1;
                        status_next       = ST_NOT_FOUND;
                        found_handle_next = '0;
                        slot_index_next   = '0;
                        state_next        = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            table_size_reg   <= TABLE_SIZE_RST;
            cmd_reg          <= CMD_INSERT;
            key_reg          <= '0;
            key_sh_reg       <= '0;
            handle_reg       <= '0;
            size_reg         <= '0;
            rem_reg          <= '0;
            div_cnt_reg      <= '0;
            slot_reg         <= '0;
            cnt_reg          <= '0;
            clr_reg          <= '0;
            done_reg         <= 1'b0;
            status_reg       <= ST_INSERTED;
            found_handle_reg <= '0;
            slot_index_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            table_size_reg   <= table_size_next;
            cmd_reg          <= cmd_next;
            key_reg          <= key_next;
            key_sh_reg       <= key_sh_next;
            handle_reg       <= handle_next;
            size_reg         <= size_next;
            rem_reg          <= rem_next;
            div_cnt_reg      <= div_cnt_next;
            slot_reg         <= slot_next;
            cnt_reg          <= cnt_next;
            clr_reg          <= clr_next;
            done_reg         <= done_next;
            status_reg       <= status_next;
            found_handle_reg <= found_handle_next;
            slot_index_reg   <= slot_index_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign found_handle = found_handle_reg;
    assign slot_index   = slot_index_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done strobe longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result shown while item still in work");

    a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_FOUND) |-> found_handle_reg == '0)
        else $error("handle not zero without a match");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_NOT_FOUND || status_reg == ST_FULL))
        |-> slot_index_reg == '0)
        else $error("slot index not zero on miss or full");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE || state_reg == S_ISSUE)
        |-> ({1'b0, slot_reg} < size_reg && cnt_reg < size_reg))
        else $error("probe outside the tables in use");

endmodule

FILE: rtl/lpht_ram.sv
`timescale 1ns / 1ps

module lpht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
